// ===== src/dsp_pkg.sv =====
// Shared types, constants and helper functions of the decimal size parser.
package dsp_pkg;

  localparam int unsigned FracDigitsMax = 18;
  localparam int unsigned QueueDepth    = 2;

  // Text bytes used by the parser
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChNul   = 8'h00;

  // Result status codes
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatOvf   = 2'd2;

  localparam logic [63:0] MagTopPos = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MagTopNeg = 64'h8000_0000_0000_0000;

  // One finished string, handed from the front to the back
  typedef struct packed {
    logic        empty;
    logic        neg;
    logic [63:0] int_part;
    logic [59:0] frac_num;
    logic [4:0]  frac_cnt;
    logic [5:0]  shift;
    logic        ovf;
  } job_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'd1) && (c <= 8'd32);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // Binary scale of a size suffix letter, zero for anything else
  function automatic logic [5:0] suffix_of(input logic [7:0] c);
    logic [5:0] s;
    case (c)
      8'h6b, 8'h4b: s = 6'd10;
      8'h6d, 8'h4d: s = 6'd20;
      8'h67, 8'h47: s = 6'd30;
      8'h74, 8'h54: s = 6'd40;
      8'h70, 8'h50: s = 6'd50;
      8'h65, 8'h45: s = 6'd60;
      default:      s = 6'd0;
    endcase
    return s;
  endfunction

  // Largest integer part that still takes digit d: floor((2^63 - d) / 10)
  function automatic logic [63:0] int_digit_limit(input logic [3:0] d);
    return (d == 4'd9) ? 64'd922337203685477579 : 64'd922337203685477580;
  endfunction

  // Ten to the power n, n up to 18
  function automatic logic [59:0] pow10(input logic [4:0] n);
    logic [59:0] p;
    case (n)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      default: p = 60'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== src/dsp_if.sv =====
// Handshake interfaces for text bytes in and parsed values out.
interface dsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last;
  modport source (output valid, output char_byte, output last, input ready);
  modport sink (input valid, input char_byte, input last, output ready);
endinterface

interface dsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

// ===== src/dsp_front.sv =====
// Byte-wise parser: tracks phase, sign, digits and suffix, emits a job on the last byte.
module dsp_front #(
  parameter int unsigned FRAC_DIGITS = dsp_pkg::FracDigitsMax
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    char_byte_i,
  input  logic          last_i,
  output logic          push_o,
  output dsp_pkg::job_t job_o
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_INT, PH_FRAC, PH_TRAIL, PH_DONE
  } phase_e;

  localparam logic [4:0] FracLimit = 5'(FRAC_DIGITS);

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [63:0] int_q, int_d;
  logic [59:0] frac_q, frac_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [5:0]  shift_q, shift_d;
  logic        ovf_q, ovf_d;

  logic [3:0]  dval;
  logic        is_dig, is_sp;

  assign dval   = char_byte_i[3:0] - 4'd0;
  assign is_dig = dsp_pkg::is_digit(char_byte_i);
  assign is_sp  = dsp_pkg::is_space(char_byte_i);

  // Advance the parse state for one byte
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    int_d   = int_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    ovf_d   = ovf_q;
    case (phase_q)
      PH_LEAD, PH_INT: begin
        if (phase_q == PH_LEAD && is_sp) begin
          phase_d = PH_LEAD;
        end else if (phase_q == PH_LEAD && char_byte_i == dsp_pkg::ChMinus) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end else if (phase_q == PH_LEAD && char_byte_i == dsp_pkg::ChPlus) begin
          phase_d = PH_INT;
        end else if (char_byte_i == dsp_pkg::ChNul) begin
          phase_d = PH_DONE;
        end else if (is_dig) begin
          phase_d = PH_INT;
          if (!ovf_q) begin
            if (int_q > dsp_pkg::int_digit_limit(dval)) begin
              ovf_d = 1'b1;
            end else begin
              int_d = (int_q << 3) + (int_q << 1) + 64'(dval);
            end
          end
        end else if (char_byte_i == dsp_pkg::ChDot) begin
          phase_d = PH_FRAC;
        end else if (is_sp) begin
          phase_d = PH_TRAIL;
        end else begin
          shift_d = dsp_pkg::suffix_of(char_byte_i);
          phase_d = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (cnt_q < FracLimit) begin
            frac_d = (frac_q << 3) + (frac_q << 1) + 60'(dval);
            cnt_d  = cnt_q + 5'd1;
          end
        end else if (is_sp) begin
          phase_d = PH_TRAIL;
        end else if (char_byte_i == dsp_pkg::ChNul) begin
          phase_d = PH_DONE;
        end else begin
          shift_d = dsp_pkg::suffix_of(char_byte_i);
          phase_d = PH_DONE;
        end
      end
      PH_TRAIL: begin
        if (!is_sp) begin
          shift_d = dsp_pkg::suffix_of(char_byte_i);
          phase_d = PH_DONE;
        end
      end
      default: phase_d = PH_DONE;
    endcase
  end

  // Hand the finished string to the queue
  assign push_o         = byte_valid_i && last_i;
  assign job_o.empty    = (phase_d == PH_LEAD);
  assign job_o.neg      = neg_d;
  assign job_o.int_part = int_d;
  assign job_o.frac_num = frac_d;
  assign job_o.frac_cnt = cnt_d;
  assign job_o.shift    = shift_d;
  assign job_o.ovf      = ovf_d;

  // Hold state, clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      neg_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      ovf_q   <= 1'b0;
    end else if (byte_valid_i) begin
      if (last_i) begin
        phase_q <= PH_LEAD;
        neg_q   <= 1'b0;
        int_q   <= '0;
        frac_q  <= '0;
        cnt_q   <= '0;
        shift_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        int_q   <= int_d;
        frac_q  <= frac_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== src/dsp_queue.sv =====
// Short job queue between the parser front and the scaling back.
module dsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dsp_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nonempty_o,
  output dsp_pkg::job_t job_o
);

  localparam int unsigned PtrW = $clog2(dsp_pkg::QueueDepth);

  dsp_pkg::job_t mem_q [dsp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(dsp_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign job_o      = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i && nonempty_o) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && nonempty_o);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(dsp_pkg::QueueDepth))
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonempty_o && !push_i |=> cnt_q == '0)
    else $error("queue count moved without a push");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !full_o && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push lost");
`endif

endmodule

// ===== src/dsp_back.sv =====
// Scaling back end: fraction times 2^shift by restoring division, range check, sign.
module dsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  dsp_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] result_value_o,
  output logic [1:0]         status_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SCALE, ST_ADD, ST_OUT
  } state_e;

  state_e        state_q;
  dsp_pkg::job_t job_q;
  logic [59:0]   den_q;
  logic [59:0]   rem_q;
  logic [63:0]   quo_q;
  logic [5:0]    iter_q;
  logic [63:0]   mag_q;
  logic          ovf_q;
  logic [63:0]   val_q;
  logic [1:0]    stat_q;

  logic [60:0] rem_sh;
  logic [63:0] lim;
  logic [59:0] den_c;

  assign rem_sh = {rem_q, 1'b0};
  assign lim    = job_q.neg ? dsp_pkg::MagTopNeg : dsp_pkg::MagTopPos;
  assign den_c  = dsp_pkg::pow10(job_i.frac_cnt);

  assign pop_o          = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o    = (state_q == ST_OUT);
  assign result_value_o = val_q;
  assign status_o       = stat_q;

  // Sequence one job: load, divide step per shift bit, scale, add, present
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      job_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      val_q   <= '0;
      stat_q  <= dsp_pkg::StatOk;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q  <= job_i;
            den_q  <= den_c;
            rem_q  <= (job_i.frac_num >= den_c) ? (den_c - 60'd1) : job_i.frac_num;
            quo_q  <= '0;
            iter_q <= job_i.shift;
            ovf_q  <= job_i.ovf;
            if (job_i.empty) begin
              val_q   <= '0;
              stat_q  <= dsp_pkg::StatEmpty;
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (iter_q == '0) begin
            state_q <= ST_SCALE;
          end else begin
            iter_q <= iter_q - 6'd1;
            if (rem_sh >= 61'(den_q)) begin
              rem_q <= 60'(rem_sh - 61'(den_q));
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[59:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
          end
        end
        ST_SCALE: begin
          if (job_q.int_part > (lim >> job_q.shift)) begin
            ovf_q <= 1'b1;
          end
          mag_q   <= job_q.int_part << job_q.shift;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (ovf_q || (quo_q > lim - mag_q)) begin
            val_q  <= job_q.neg ? (64'd0 - lim) : lim;
            stat_q <= dsp_pkg::StatOvf;
          end else begin
            val_q  <= job_q.neg ? (64'd0 - (mag_q + quo_q)) : (mag_q + quo_q);
            stat_q <= dsp_pkg::StatOk;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/decimal_with_size_suffix_parser.sv =====
// Top level of the decimal parser with binary size suffix.
//   channel  dir  payload                         word accepted when
//   in_i     in   char_byte[7:0], last            in_i.valid && in_i.ready
//   out_o    out  result_value[63:0] s, status    out_o.valid && out_o.ready
// The front takes one byte per cycle; ready drops only while the two-entry job
// queue is full. The back handles one string at a time, with shift 0..60 from
// the suffix: load, one restoring-division step per cycle plus a final check,
// scale, add, then holds the result until taken. Empty strings go straight to the hold.
// Reset clears all control state at once.
module decimal_with_size_suffix_parser #(
  parameter int unsigned FRAC_DIGITS = dsp_pkg::FracDigitsMax
) (
  input  logic clk_i,
  input  logic rst_ni,
  dsp_in_if.sink    in_i,
  dsp_out_if.source out_o
);

  logic          push, full, pop, nonempty;
  dsp_pkg::job_t job_in, job_out;

  assign in_i.ready = !full;

  dsp_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_i.valid && !full),
    .char_byte_i  (in_i.char_byte),
    .last_i       (in_i.last),
    .push_o       (push),
    .job_o        (job_in)
  );

  dsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job_in),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .job_o      (job_out)
  );

  dsp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (nonempty),
    .job_i          (job_out),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_value_o (out_o.result_value),
    .status_o       (out_o.status)
  );

endmodule

// ===== tb/dsp_tb_if.sv =====
// Testbench-side note: the handshake interfaces come from the RTL file dsp_if.sv.
// This file holds the scoreboard class that predicts parsed values.
package dsp_tb_pkg;
  import dsp_pkg::*;

  // Predict parsed values from text words and check results in order
  class parse_scoreboard;
    logic [2:0]  phase;
    logic        neg;
    logic [63:0] ipart;
    logic [63:0] fnum;
    int unsigned fcnt;
    int unsigned shift;
    logic        ovf;
    logic [63:0] exp_value[$];
    logic [1:0]  exp_status[$];
    int unsigned errors;
    int unsigned results;
    int unsigned n_ovf;
    int unsigned n_empty;

    function new();
      clear();
      errors = 0;
      results = 0;
      n_ovf = 0;
      n_empty = 0;
    endfunction

    function void clear();
      phase = 3'd0;
      neg = 1'b0;
      ipart = '0;
      fnum = '0;
      fcnt = 0;
      shift = 0;
      ovf = 1'b0;
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - 8'd48);
      if (ovf) return;
      if (ipart > ((64'h8000_0000_0000_0000 - d) / 10)) begin
        ovf = 1'b1;
        return;
      end
      ipart = ipart * 10 + d;
    endfunction

    function void stop_at(logic [7:0] c);
      shift = suffix_of(c);
      phase = 3'd4;
    endfunction

    function void int_char(logic [7:0] c);
      if (is_digit(c)) begin
        add_digit(c);
        phase = 3'd1;
      end else if (c == ChDot) begin
        phase = 3'd2;
      end else if (is_space(c)) begin
        phase = 3'd3;
      end else begin
        stop_at(c);
      end
    endfunction

    // Work out the value of a finished string
    function void close_string(int unsigned frac_max);
      logic [63:0] lim, den, rem, q, mag;
      logic [1:0]  st;
      logic        o;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      den = 64'd1;
      q = '0;
      mag = '0;
      st = StatOk;
      o = ovf;
      if (phase == 3'd0) begin
        exp_value.push_back('0);
        exp_status.push_back(StatEmpty);
        return;
      end
      for (int i = 0; i < fcnt && i < 18; i++) den = den * 10;
      rem = fnum;
      if (rem >= den) rem = den - 1;
      for (int i = 0; i < shift; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      if (!o) begin
        if (ipart > (lim >> shift)) begin
          o = 1'b1;
        end else begin
          mag = ipart << shift;
          if (q > lim - mag) o = 1'b1;
          else mag = mag + q;
        end
      end
      if (o) begin
        mag = lim;
        st = StatOvf;
      end
      exp_value.push_back(neg ? (64'd0 - mag) : mag);
      exp_status.push_back(st);
    endfunction

    // Note one accepted text word
    function void note_word(logic [7:0] c, logic lst, int unsigned frac_max);
      case (phase)
        3'd0: begin
          if (!is_space(c)) begin
            if (c == ChMinus) begin
              neg = 1'b1;
              phase = 3'd1;
            end else if (c == ChPlus) begin
              phase = 3'd1;
            end else if (c == ChNul) begin
              phase = 3'd4;
            end else begin
              int_char(c);
            end
          end
        end
        3'd1: begin
          if (c == ChNul) phase = 3'd4;
          else int_char(c);
        end
        3'd2: begin
          if (is_digit(c)) begin
            if (fcnt < frac_max && fcnt < 18) begin
              fnum = fnum * 10 + 64'(c - 8'd48);
              fcnt++;
            end
          end else if (is_space(c)) begin
            phase = 3'd3;
          end else if (c == ChNul) begin
            phase = 3'd4;
          end else begin
            stop_at(c);
          end
        end
        3'd3: begin
          if (!is_space(c)) stop_at(c);
        end
        default: phase = 3'd4;
      endcase
      if (lst) begin
        close_string(frac_max);
        clear();
      end
    endfunction

    // Check one accepted result word against the oldest expectation
    function void check_result(logic [63:0] v, logic [1:0] s);
      logic [63:0] ev;
      logic [1:0]  es;
      results++;
      if (exp_value.size() == 0) begin
        $error("unexpected result: value %0d status %0d", $signed(v), s);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      if (es == StatOvf) n_ovf++;
      if (es == StatEmpty) n_empty++;
      if (v !== ev) begin
        $error("result_value: expected %0d, actual %0d", $signed(ev), $signed(v));
        errors++;
      end
      if (s !== es) begin
        $error("status: expected %0d, actual %0d", es, s);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of the decimal parser with binary size suffix.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsp_pkg::*;
  import dsp_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   send_idle;
  int   recv_idle;
  bit   hold_off;
  bit   sending_done;

  dsp_in_if  text_if ();
  dsp_out_if value_if ();

  parse_scoreboard sb;

  decimal_with_size_suffix_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if.sink),
    .out_o  (value_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one text word, idling at random first
  task automatic send_word(input logic [7:0] c, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.char_byte <= c;
    text_if.last      <= lst;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    sb.note_word(c, lst, FracDigitsMax);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'd48 + 8'($urandom_range(9));
  endfunction

  // Build a mostly well-formed number string with random content
  task automatic send_random_number();
    logic [7:0] buf_q[$];
    int         n;
    string      sfx;
    sfx = "kKmMgGtTpPeE";
    repeat ($urandom_range(2)) buf_q.push_back($urandom_range(1) ? 8'd32 : 8'($urandom_range(1, 32)));
    case ($urandom_range(2))
      0: buf_q.push_back(ChMinus);
      1: buf_q.push_back(ChPlus);
      default: ;
    endcase
    n = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 6);
    repeat (n) buf_q.push_back(rand_digit());
    if ($urandom_range(1)) begin
      buf_q.push_back(ChDot);
      n = ($urandom_range(5) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 5);
      repeat (n) buf_q.push_back(rand_digit());
    end
    repeat ($urandom_range(1)) buf_q.push_back(8'd32);
    if ($urandom_range(3) != 0) buf_q.push_back(sfx[$urandom_range(11)]);
    if ($urandom_range(7) == 0) buf_q.push_back(8'($urandom));
    if ($urandom_range(9) == 0) begin
      // broken or noisy string
      buf_q.insert($urandom_range(buf_q.size()), 8'($urandom));
    end
    if (buf_q.size() == 0) buf_q.push_back(8'd32);
    for (int i = 0; i < buf_q.size(); i++) send_word(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    value_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (value_if.valid && value_if.ready)
        sb.check_result(value_if.result_value, value_if.status);
      if (hold_off) value_if.ready <= 1'b0;
      else value_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver hold-off counted in its own process
  initial begin
    hold_off = 1'b0;
    @(posedge rst_ni);
    repeat (2000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    sb = new();
    sending_done = 1'b0;
    rst_ni = 1'b0;
    text_if.valid = 1'b0;
    text_if.char_byte = '0;
    text_if.last = 1'b0;
    send_idle = 10;
    recv_idle = 60;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: extremes, suffixes, special cases
    send_string("9223372036854775807");
    send_string("-9223372036854775808");
    send_string("9223372036854775808");
    send_string("  \t ");
    send_string("-");
    send_string("1.5k");
    send_string("-0.999999999999999999999E");
    send_string("7e");
    send_string("8E");
    send_word(8'd49, 1'b0);
    send_word(ChNul, 1'b0);
    send_word(8'd107, 1'b1);
    send_word(8'd255, 1'b0);
    send_word(8'd128, 1'b1);
    send_string("12 x");
    send_string("3 .m");
    send_string("+.25 P");
    send_string("99999999999999999999g");
    send_string("1.000000000000000000001t");

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 10 : 0;
      repeat (40) begin
        send_random_number();
      end
      // plain noise words
      repeat (60) send_word(8'($urandom), $urandom_range(5) == 0);
      repeat (40) send_word(8'($urandom), 1'b0);
      send_word(8'($urandom), 1'b1);
    end
    text_if.valid <= 1'b0;
    sending_done = 1'b1;

    while (sb.exp_value.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Checked %0d parsed values (%0d overflow, %0d empty).",
             sb.results, sb.n_ovf, sb.n_empty);
    $display("Random strings covered signs, fractions, all suffixes and noise words.");
    if (sb.errors == 0 && sb.exp_value.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
